// File: sv/rgbcm_pkg.sv
// shared types and constants of the rgb color matrix
package rgbcm_pkg;

  localparam int unsigned CHAN_W   = 16;
  localparam int unsigned NUM_CH   = 3;
  localparam int unsigned SLOT_W   = 20;
  localparam int unsigned ROW_W    = NUM_CH * SLOT_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;
  localparam int unsigned PROD_W   = SLOT_W + CHAN_W + 1;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned OFS_SHIFT = 14;

  // register indexes of the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH16   = 3'd0,
    REG_GAIN_RED  = 3'd1,
    REG_GAIN_GRN  = 3'd2,
    REG_GAIN_BLU  = 3'd3,
    REG_OFFSETS   = 3'd4
  } reg_idx_e;

  // reset values: identity matrix, zero offsets, 16-bit channels
  localparam logic [ROW_W-1:0] GAIN_RED_RST = 60'd65536;
  localparam logic [ROW_W-1:0] GAIN_GRN_RST = 60'd65536 << SLOT_W;
  localparam logic [ROW_W-1:0] GAIN_BLU_RST = 60'd65536 << (2 * SLOT_W);

  localparam logic [CHAN_W-1:0] MAX_8  = 16'd255;
  localparam logic [CHAN_W-1:0] MAX_16 = 16'd65535;

  typedef struct packed {
    logic                          depth16;
    logic [NUM_CH-1:0][ROW_W-1:0]  gain_rows;
    logic [ROW_W-1:0]              offsets;
  } cfg_t;

  // pipeline advance strobes shared by all lanes
  typedef struct packed {
    logic adv_mul;
    logic adv_sum;
    logic adv_rnd;
  } pipe_ctl_t;

endpackage

// File: sv/rgbcm_if.sv
// pixel channel interfaces for input and output words
interface rgbcm_in_if;
  import rgbcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);
endinterface

interface rgbcm_out_if;
  import rgbcm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                output ready);
endinterface

// File: sv/rgb_color_matrix_3x4.sv
// rgb 3x4 color matrix: three parallel channel lanes and an output register
// latency path: an accepted input word passes the multiply, sum and round registers, then the output register
// throughput: one word per clock while the output is not stalled, three 20x17 multipliers per lane in stage one
// stalls propagate back stage by stage, empty stages fill while output waits
// reset: identity matrix, zero offsets, 16-bit channels, pipeline empty
module rgb_color_matrix_3x4 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgbcm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rgbcm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  rgbcm_in_if.sink                            in_ch,
  rgbcm_out_if.source                         out_ch
);
  import rgbcm_pkg::*;

  cfg_t                          cfg;
  pipe_ctl_t                     ctl;
  logic                          take;
  logic                          v_mul_q, v_sum_q, v_rnd_q;
  logic [NUM_CH-1:0][CHAN_W-1:0] samples;
  logic [NUM_CH-1:0][CHAN_W-1:0] res;

  rgbcm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // stage advance: a stage moves when empty or when the next one moves
  assign ctl.adv_rnd = !v_rnd_q || take;
  assign ctl.adv_sum = !v_sum_q || ctl.adv_rnd;
  assign ctl.adv_mul = !v_mul_q || ctl.adv_sum;
  assign in_ch.ready = ctl.adv_mul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_mul_q <= 1'b0;
      v_sum_q <= 1'b0;
      v_rnd_q <= 1'b0;
    end else begin
      if (ctl.adv_mul) v_mul_q <= in_ch.valid;
      if (ctl.adv_sum) v_sum_q <= v_mul_q;
      if (ctl.adv_rnd) v_rnd_q <= v_sum_q;
    end
  end

  assign samples[0] = in_ch.red_in;
  assign samples[1] = in_ch.green_in;
  assign samples[2] = in_ch.blue_in;

  // one lane per output channel
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    rgbcm_lane u_lane (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .depth16_i  (cfg.depth16),
      .samples_i  (samples),
      .gain_row_i (cfg.gain_rows[c]),
      .offset_i   (cfg.offsets[c*SLOT_W +: SLOT_W]),
      .res_o      (res[c])
    );
  end

  rgbcm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_rnd_q),
    .res_i   (res),
    .take_o  (take),
    .out_ch  (out_ch)
  );

endmodule

// File: sv/rgbcm_cfg.sv
// configuration register file of the color matrix
module rgbcm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rgbcm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rgbcm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output rgbcm_pkg::cfg_t                     cfg_o
);
  import rgbcm_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DEPTH16:  cfg_d.depth16      = cfg_data_i[0];
        REG_GAIN_RED: cfg_d.gain_rows[0] = cfg_data_i;
        REG_GAIN_GRN: cfg_d.gain_rows[1] = cfg_data_i;
        REG_GAIN_BLU: cfg_d.gain_rows[2] = cfg_data_i;
        REG_OFFSETS:  cfg_d.offsets      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth16      <= 1'b1;
      cfg_q.gain_rows[0] <= GAIN_RED_RST;
      cfg_q.gain_rows[1] <= GAIN_GRN_RST;
      cfg_q.gain_rows[2] <= GAIN_BLU_RST;
      cfg_q.offsets      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/rgbcm_lane.sv
// one output channel: three products, sum with offset, round and saturate
module rgbcm_lane (
  input  logic                                      clk_i,
  input  rgbcm_pkg::pipe_ctl_t                      ctl_i,
  input  logic                                      depth16_i,
  input  logic [rgbcm_pkg::NUM_CH-1:0][rgbcm_pkg::CHAN_W-1:0] samples_i,
  input  logic [rgbcm_pkg::ROW_W-1:0]               gain_row_i,
  input  logic [rgbcm_pkg::SLOT_W-1:0]              offset_i,
  output logic [rgbcm_pkg::CHAN_W-1:0]              res_o
);
  import rgbcm_pkg::*;

  logic signed [PROD_W-1:0] prod_q [NUM_CH];
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [CHAN_W-1:0]        res_q, res_d;

  // stage 1: mask samples by depth, one multiplier per input channel
  for (genvar k = 0; k < NUM_CH; k++) begin : g_mul
    logic [CHAN_W-1:0]        smp;
    logic signed [SLOT_W-1:0] gain;
    logic signed [CHAN_W:0]   smp_s;
    logic signed [PROD_W-1:0] prod_d;

    assign smp    = depth16_i ? samples_i[k] : {8'd0, samples_i[k][7:0]};
    assign gain   = signed'(gain_row_i[k*SLOT_W +: SLOT_W]);
    assign smp_s  = signed'({1'b0, smp});
    assign prod_d = PROD_W'(gain * smp_s);

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv_mul) begin
        prod_q[k] <= prod_d;
      end
    end
  end

  // stage 2: add the products and the scaled offset
  always_comb begin
    logic signed [SUM_W-1:0] ofs;
    ofs   = signed'({{(SUM_W-SLOT_W-OFS_SHIFT){offset_i[SLOT_W-1]}}, offset_i,
                     {OFS_SHIFT{1'b0}}});
    sum_d = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + ofs;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_sum) begin
      sum_q <= sum_d;
    end
  end

  // stage 3: round half to even, clamp to the channel range
  always_comb begin
    logic [SUM_W-FRAC_W-1:0] q;
    logic [FRAC_W-1:0]       frac;
    logic                    up;
    logic [SUM_W-FRAC_W:0]   qr;
    logic [CHAN_W-1:0]       maxv;
    q    = sum_q[SUM_W-1:FRAC_W];
    frac = sum_q[FRAC_W-1:0];
    up   = (frac > 16'h8000) || ((frac == 16'h8000) && q[0]);
    qr   = {1'b0, q} + (SUM_W-FRAC_W+1)'(up);
    maxv = depth16_i ? MAX_16 : MAX_8;
    if (sum_q[SUM_W-1] || (sum_q == '0)) begin
      res_d = '0;
    end else if (qr > (SUM_W-FRAC_W+1)'(maxv)) begin
      res_d = maxv;
    end else begin
      res_d = qr[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_rnd) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: sv/rgbcm_merge.sv
// gathers the three lane results into the registered output word
module rgbcm_merge (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              valid_i,
  input  logic [rgbcm_pkg::NUM_CH-1:0][rgbcm_pkg::CHAN_W-1:0] res_i,
  output logic                                              take_o,
  rgbcm_out_if.source                                       out_ch
);
  import rgbcm_pkg::*;

  logic                          valid_q;
  logic [NUM_CH-1:0][CHAN_W-1:0] word_q;

  // output register frees up when empty or when the word is taken
  assign take_o = !valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      word_q <= res_i;
    end
  end

  assign out_ch.valid     = valid_q;
  assign out_ch.red_out   = word_q[0];
  assign out_ch.green_out = word_q[1];
  assign out_ch.blue_out  = word_q[2];

endmodule
